>>> sv/flss_pkg.sv
`timescale 1ns / 1ps

package flss_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int NUM_W     = 16;
    localparam int DEN_W     = 15;
    localparam int OUT_IDX_W = 6;
    localparam int PROD_W    = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] a_num;
        logic [DEN_W-1:0] a_den;
        logic [NUM_W-1:0] b_num;
        logic [DEN_W-1:0] b_den;
    } t_xreq;

    typedef struct packed {
        logic done;
        logic less;
        logic equal;
    } t_xres;

    typedef enum logic [1:0] {
        XU_IDLE,
        XU_MUL1,
        XU_MUL2,
        XU_DONE
    } t_xphase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_I,
        ST_SORT_LDI,
        ST_SORT_RDJ,
        ST_SORT_CMP0,
        ST_SORT_CMP,
        ST_SORT_NXJ,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_SRCH_RD,
        ST_SRCH_CMP0,
        ST_SRCH_CMP,
        ST_SRCH_OUT
    } t_state;

endpackage

>>> sv/flss_cross_cmp.sv
`timescale 1ns / 1ps

module flss_cross_cmp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  flss_pkg::t_xreq i_req,
    output flss_pkg::t_xres o_res
);
    import flss_pkg::*;

    t_xphase r_phase, n_phase;
    logic [NUM_W-1:0] r_an, r_bn;
    logic [DEN_W-1:0] r_ad, r_bd;
    logic [PROD_W-1:0] r_p1, r_p2;
    logic signed [NUM_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= XU_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == XU_IDLE && i_req.start) begin
            r_an <= i_req.a_num;
            r_ad <= i_req.a_den;
            r_bn <= i_req.b_num;
            r_bd <= i_req.b_den;
        end
        if (r_phase == XU_MUL1) begin
            r_p1 <= w_prod;
        end
        if (r_phase == XU_MUL2) begin
            r_p2 <= w_prod;
        end
    end

    // one shared multiplier: a_num * b_den, then b_num * a_den
    always_comb begin
        if (r_phase == XU_MUL2) begin
            w_ma = $signed(r_bn);
            w_mb = $signed({1'b0, r_ad});
        end else begin
            w_ma = $signed(r_an);
            w_mb = $signed({1'b0, r_bd});
        end
        w_prod = w_ma * w_mb;
    end

    always_comb begin
        n_phase     = r_phase;
        o_res.done  = 1'b0;
        o_res.less  = $signed(r_p1) < $signed(r_p2);
        o_res.equal = (r_p1 == r_p2);
        case (r_phase)
            XU_IDLE: begin
                if (i_req.start) begin
                    n_phase = XU_MUL1;
                end
            end
            XU_MUL1: n_phase = XU_MUL2;
            XU_MUL2: n_phase = XU_DONE;
            XU_DONE: begin
                o_res.done = 1'b1;
                n_phase    = XU_IDLE;
            end
            default: n_phase = XU_IDLE;
        endcase
    end

endmodule

>>> sv/fraction_list_sort_search.sv
`timescale 1ns / 1ps
// Channel   Dir  Word                                                  Marker
// ------------------------------------------------------------------------------------
// s side    in   tdata: command[1:0] numerator[17:2] denominator[32:18]  -
// m side    out  tdata: out_numerator[15:0] out_denominator[30:16]       tlast: last
//                       out_index[36:31]                                 tuser: found
//
// Load and clear complete in idle. Search reads and then compares each entry
// visited; sort compares each (i, j) pair with i != j and then emits every entry;
// the shared cross multiplier (two products, one compare) does every compare.
// Synchronous active-low reset empties the list; entry contents are kept.
// Input is not ready while a command runs; a stalled output holds the sequencer.

module fraction_list_sort_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [flss_pkg::IN_DATA_W-1:0]     i_s_tdata,  // command, numerator, denominator
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [flss_pkg::OUT_DATA_W-1:0]    o_m_tdata,  // out_numerator, out_denominator, out_index
    output logic                               o_m_tlast,  // last
    output logic                               o_m_tuser   // found
);
    import flss_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    t_entry r_ei, n_ei;
    t_entry r_srch, n_srch;
    logic r_hit, n_hit;
    logic [IDX_W-1:0] r_hidx, n_hidx;

    logic r_ovalid, n_ovalid;
    logic [NUM_W-1:0] r_onum, n_onum;
    logic [DEN_W-1:0] r_oden, n_oden;
    logic [OUT_IDX_W-1:0] r_oidx, n_oidx;
    logic r_ofound, n_ofound;
    logic r_olast, n_olast;

    logic w_we, w_re;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    t_entry w_wdata;
    t_xreq w_xreq;
    t_xres w_xres;
    t_cmd w_cmd;
    t_entry w_in;
    logic [CNT_W-1:0] w_last_idx;
    logic w_ofree;

    flss_cross_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_xreq),
        .o_res   (w_xres)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_DATA_W'({r_oidx, r_oden, r_onum});
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ofound;

    assign w_cmd      = t_cmd'(i_s_tdata[1:0]);
    assign w_in.num   = i_s_tdata[17:2];
    assign w_in.den   = i_s_tdata[32:18];
    assign w_last_idx = r_count - 1'b1;
    assign w_ofree    = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_ei     <= n_ei;
        r_srch   <= n_srch;
        r_hit    <= n_hit;
        r_hidx   <= n_hidx;
        r_onum   <= n_onum;
        r_oden   <= n_oden;
        r_oidx   <= n_oidx;
        r_ofound <= n_ofound;
        r_olast  <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_ei     = r_ei;
        n_srch   = r_srch;
        n_hit    = r_hit;
        n_hidx   = r_hidx;
        n_ovalid = r_ovalid && !i_m_tready;
        n_onum   = r_onum;
        n_oden   = r_oden;
        n_oidx   = r_oidx;
        n_ofound = r_ofound;
        n_olast  = r_olast;
        w_we     = 1'b0;
        w_waddr  = r_j;
        w_wdata  = r_ei;
        w_re     = 1'b0;
        w_raddr  = r_k;
        w_xreq.start = 1'b0;
        w_xreq.a_num = r_rdata.num;
        w_xreq.a_den = r_rdata.den;
        w_xreq.b_num = r_ei.num;
        w_xreq.b_den = r_ei.den;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (w_cmd)
                        CMD_LOAD: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                w_we    = 1'b1;
                                w_waddr = r_count[IDX_W-1:0];
                                w_wdata = w_in;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_SORT: begin
                            if (r_count != '0) begin
                                n_i     = '0;
                                n_state = ST_SORT_I;
                            end
                        end
                        CMD_SEARCH: begin
                            n_srch = w_in;
                            n_k    = '0;
                            n_hit  = 1'b0;
                            n_hidx = '0;
                            if (r_count == '0) begin
                                n_state = ST_SRCH_OUT;
                            end else begin
                                n_state = ST_SRCH_RD;
                            end
                        end
                        CMD_CLEAR: n_count = '0;
                        default: n_count = r_count;
                    endcase
                end
            end
            ST_SORT_I: begin
                w_re    = 1'b1;
                w_raddr = r_i;
                n_state = ST_SORT_LDI;
            end
            ST_SORT_LDI: begin
                n_ei    = r_rdata;
                n_j     = '0;
                n_state = ST_SORT_RDJ;
            end
            ST_SORT_RDJ: begin
                // entry i lives in r_ei meanwhile and never beats itself: skip
                if (r_j == r_i) begin
                    n_state = ST_SORT_NXJ;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_j;
                    n_state = ST_SORT_CMP0;
                end
            end
            ST_SORT_CMP0: begin
                w_xreq.start = 1'b1;
                n_state      = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (w_xres.done) begin
                    if (w_xres.less) begin
                        w_we    = 1'b1;
                        w_waddr = r_j;
                        w_wdata = r_ei;
                        n_ei    = r_rdata;
                    end
                    n_state = ST_SORT_NXJ;
                end
            end
            ST_SORT_NXJ: begin
                if (CNT_W'(r_j) == w_last_idx) begin
                    w_we    = 1'b1;
                    w_waddr = r_i;
                    w_wdata = r_ei;
                    if (CNT_W'(r_i) == w_last_idx) begin
                        n_k     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_SORT_I;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_SORT_RDJ;
                end
            end
            ST_EMIT_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_rdata.num;
                    n_oden   = r_rdata.den;
                    n_oidx   = OUT_IDX_W'(r_k);
                    n_ofound = 1'b0;
                    n_olast  = (CNT_W'(r_k) == w_last_idx);
                    if (CNT_W'(r_k) == w_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k;
                n_state = ST_SRCH_CMP0;
            end
            ST_SRCH_CMP0: begin
                w_xreq.start = 1'b1;
                w_xreq.b_num = r_srch.num;
                w_xreq.b_den = r_srch.den;
                n_state      = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (w_xres.done) begin
                    if (w_xres.equal) begin
                        n_hit   = 1'b1;
                        n_hidx  = r_k;
                        n_state = ST_SRCH_OUT;
                    end else if (CNT_W'(r_k) == w_last_idx) begin
                        n_state = ST_SRCH_OUT;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_OUT: begin
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_onum   = '0;
                    n_oden   = '0;
                    n_oidx   = OUT_IDX_W'(r_hidx);
                    n_ofound = r_hit;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_full_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && w_cmd == CMD_LOAD && r_count == CNT_W'(CAPACITY))
        |=> (r_count == CNT_W'(CAPACITY)))
        else $error("load into full list changed count");

    a_sort_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT_RDJ) |-> (CNT_W'(r_i) < r_count && CNT_W'(r_j) < r_count))
        else $error("sort index outside loaded entries");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xres.done |-> (r_state == ST_SORT_CMP || r_state == ST_SRCH_CMP))
        else $error("compare finished while sequencer not waiting");

    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("found flag on a word that is not last");

endmodule
